@@ rtl/lkv_pkg.sv @@
// shared types and constants of the lru key-value cache
package lkv_pkg;

   localparam int KEY_W            = 32;
   localparam int DATA_W           = 32;
   localparam int CAP_W            = 5;
   localparam int CAP_RESET        = 16;
   localparam int CAPACITY_DEFAULT = 16;
   localparam int REQ_TDATA_W      = KEY_W + DATA_W;
   localparam int RSP_TDATA_W      = DATA_W;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_IW         = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW         = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_GET = 1'b0,
      OP_SET = 1'b1
   } op_kind_type;

   typedef struct packed {
      op_kind_type              kind;
      logic signed [KEY_W-1:0]  key;
      logic signed [DATA_W-1:0] data;
   } item_type;

endpackage

@@ rtl/lkv_ram.sv @@
// generic single-write, single-read ram with registered read data
module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lkv_front.sv @@
// input side: accepts request beats, decodes the operation, queues them for the back end
module lkv_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lkv_pkg::REQ_TDATA_W-1:0] req_tdata,  // key, data_in
   input  logic [0:0]                    req_tuser,  // kind
   output logic                          q_valid,
   input  logic                          q_ready,
   output lkv_pkg::item_type             q_item
);

   lkv_pkg::item_type              entry_ff [lkv_pkg::QUEUE_DEPTH];
   logic [lkv_pkg::QUEUE_IW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [lkv_pkg::QUEUE_IW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [lkv_pkg::QUEUE_CW-1:0]   fill_ff, fill_in;
   lkv_pkg::item_type              decoded;
   logic                           push;
   logic                           pop;

   always_comb begin
      decoded.kind = (req_tuser[0] == 1'b1) ? lkv_pkg::OP_SET : lkv_pkg::OP_GET;
      decoded.key  = req_tdata[lkv_pkg::KEY_W-1:0];
      decoded.data = req_tdata[lkv_pkg::REQ_TDATA_W-1:lkv_pkg::KEY_W];
   end

   assign req_tready = (fill_ff != lkv_pkg::QUEUE_CW'(lkv_pkg::QUEUE_DEPTH));
   assign q_valid    = (fill_ff != '0);
   assign q_item     = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

@@ rtl/lkv_back.sv @@
// back end: key match, recency update, eviction, value memory and response register
module lkv_back #(
   parameter int CAPACITY = lkv_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lkv_pkg::CAP_W-1:0]         csr_wdata,
   input  logic                              q_valid,
   output logic                              q_ready,
   input  lkv_pkg::item_type                 q_item,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lkv_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [0:0]                        rsp_tuser,
   output logic [$clog2(CAPACITY + 1)-1:0]   fill_count
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

   typedef enum logic [3:0] {
      ST_FETCH = 4'b0001,
      ST_LOOK  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type                        state_ff, state_in;
   lkv_pkg::item_type                item_ff, item_in;
   logic [lkv_pkg::CAP_W-1:0]        capacity_ff, capacity_in;
   logic [CAPACITY-1:0]              valid_ff, valid_in;
   logic [IW-1:0]                    rank_ff [CAPACITY];
   logic [IW-1:0]                    rank_in [CAPACITY];
   logic [lkv_pkg::KEY_W-1:0]        key_ff [CAPACITY];
   logic [CW-1:0]                    count_ff, count_in;

   logic [CAPACITY-1:0]              hit_vec_ff, hit_vec;
   logic                             hit_any_ff;
   logic [IW-1:0]                    hit_idx_ff, hit_idx;
   logic [IW-1:0]                    hit_rank_ff, hit_rank;
   logic                             full_ff, full;
   logic [CAPACITY-1:0]              slot_vec_ff, slot_vec;
   logic [IW-1:0]                    slot_idx_ff, slot_idx;
   logic [CAPACITY-1:0]              victim_vec;
   logic [CAPACITY-1:0]              free_vec;
   logic [EW-1:0]                    cap_eff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [lkv_pkg::DATA_W-1:0]       rsp_data_ff, rsp_data_in;

   logic                             out_free;
   logic                             is_set;
   logic                             exec_fire;
   logic                             promote;
   logic                             insert;
   logic                             done;
   logic                             ram_we;
   logic                             ram_re;
   logic [IW-1:0]                    ram_waddr;
   logic [lkv_pkg::DATA_W-1:0]       ram_rdata;

   // capacity clamp to 1 .. CAPACITY
   always_comb begin
      cap_eff = EW'(capacity_ff);
      if (cap_eff == '0) begin
         cap_eff = EW'(1);
      end
      if (cap_eff > EW'(CAPACITY)) begin
         cap_eff = EW'(CAPACITY);
      end
   end

   // lookup stage
   always_comb begin
      hit_idx  = '0;
      hit_rank = '0;
      slot_idx = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         hit_vec[j]    = valid_ff[j] && (key_ff[j] == item_ff.key);
         victim_vec[j] = valid_ff[j] && (CW'(rank_ff[j]) == count_ff - CW'(1));
      end
      free_vec = ~valid_ff & (valid_ff + CAPACITY'(1));
      full     = (EW'(count_ff) >= cap_eff);
      slot_vec = full ? victim_vec : free_vec;
      for (int j = 0; j < CAPACITY; j++) begin
         if (hit_vec[j]) begin
            hit_idx  = hit_idx | IW'(j);
            hit_rank = hit_rank | rank_ff[j];
         end
         if (slot_vec[j]) begin
            slot_idx = slot_idx | IW'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOK) begin
         hit_vec_ff  <= hit_vec;
         hit_any_ff  <= |hit_vec;
         hit_idx_ff  <= hit_idx;
         hit_rank_ff <= hit_rank;
         full_ff     <= full;
         slot_vec_ff <= slot_vec;
         slot_idx_ff <= slot_idx;
      end
   end

   // execute stage
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign is_set    = (item_ff.kind == lkv_pkg::OP_SET);
   assign exec_fire = (state_ff == ST_EXEC) && (is_set || hit_any_ff || out_free);
   assign promote   = exec_fire && hit_any_ff;
   assign insert    = exec_fire && is_set && !hit_any_ff;
   assign done      = (exec_fire && !(!is_set && hit_any_ff))
                      || ((state_ff == ST_RESP) && out_free);
   assign q_ready   = (state_ff == ST_FETCH) || done;

   assign ram_we    = exec_fire && is_set;
   assign ram_waddr = hit_any_ff ? hit_idx_ff : slot_idx_ff;
   assign ram_re    = exec_fire && !is_set && hit_any_ff;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int j = 0; j < CAPACITY; j++) begin
         rank_in[j] = rank_ff[j];
         if (promote) begin
            if (hit_vec_ff[j]) begin
               rank_in[j] = '0;
            end else if (valid_ff[j] && (rank_ff[j] < hit_rank_ff)) begin
               rank_in[j] = rank_ff[j] + 1'b1;
            end
         end else if (insert) begin
            if (slot_vec_ff[j]) begin
               valid_in[j] = 1'b1;
               rank_in[j]  = '0;
            end else if (valid_ff[j]) begin
               rank_in[j] = rank_ff[j] + 1'b1;
            end
         end
      end
      if (insert && !full_ff) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < CAPACITY; j++) begin
         if (insert && slot_vec_ff[j]) begin
            key_ff[j] <= item_ff.key;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      if (q_valid && q_ready) begin
         item_in  = q_item;
         state_in = ST_LOOK;
      end else begin
         case (state_ff)
            ST_FETCH: state_in = ST_FETCH;
            ST_LOOK:  state_in = ST_EXEC;
            ST_EXEC: begin
               if (exec_fire) begin
                  state_in = done ? ST_FETCH : ST_RESP;
               end
            end
            ST_RESP: begin
               if (done) begin
                  state_in = ST_FETCH;
               end
            end
            default: state_in = ST_FETCH;
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_data_in  = rsp_data_ff;
      if (exec_fire && !is_set && !hit_any_ff) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = 1'b0;
         rsp_data_in  = '1;
      end else if ((state_ff == ST_RESP) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = 1'b1;
         rsp_data_in  = ram_rdata;
      end
   end

   assign capacity_in = csr_we ? csr_wdata : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         capacity_ff  <= lkv_pkg::CAP_W'(lkv_pkg::CAP_RESET);
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < CAPACITY; j++) begin
            rank_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int j = 0; j < CAPACITY; j++) begin
            rank_ff[j] <= rank_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_found_ff <= rsp_found_in;
      rsp_data_ff <= rsp_data_in;
   end

   lkv_ram #(
      .WIDTH (lkv_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (item_ff.data),
      .rd_en   (ram_re),
      .rd_addr (hit_idx_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign fill_count = count_ff;

endmodule

@@ rtl/lru_key_value_cache_unit.sv @@
// top level of the lru key-value cache
//
//   channel   direction  beat payload
//   req_      in         tdata: key, data_in   tuser: kind
//   rsp_      out        tdata: data_out       tuser: found
//   csr_      in         wdata: capacity_in_use
//
// a set or a get miss ends in execute; a get hit adds a value memory read state
// the key match over all entries runs in lookup, the recency update in execute
// reset clears the queue, valid bits, recency ranks and fill; capacity returns to 16
// a two-beat queue lets requests be taken while a response waits on rsp_tready
module lru_key_value_cache_unit #(
   parameter int CAPACITY = lkv_pkg::CAPACITY_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lkv_pkg::REQ_TDATA_W-1:0] req_tdata,   // key, data_in
   input  logic [0:0]                      req_tuser,   // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lkv_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // data_out
   output logic [0:0]                      rsp_tuser,   // found
   input  logic                            csr_we,
   input  logic [lkv_pkg::CAP_W-1:0]       csr_wdata
);

   logic                          q_valid;
   logic                          q_ready;
   lkv_pkg::item_type             q_item;
   logic [$clog2(CAPACITY + 1)-1:0] fill_count;

   lkv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   lkv_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fill_count (fill_count)
   );

   a_queue_holds: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_ready |=> q_valid && $stable(q_item))
      else $error("queue head changed while stalled");

   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> q_valid)
      else $error("accepted beat missing from queue");

   a_miss_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '1)
      else $error("miss response without all-ones data");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count <= ($clog2(CAPACITY + 1))'(CAPACITY))
      else $error("fill count above capacity");

endmodule
